FILE: hdl/ctbe_pkg.sv
// ----------------------------------------------------------------------------
// ctbe_pkg: shared types and constants of the cursor text buffer editor
// Buffer depth, command and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package ctbe_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int PTR_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int CHAR_W       = 8;
  localparam int RIDX_W       = 6;
  localparam int ACT_W        = 3;
  localparam int STAT_W       = 2;

  localparam logic [PTR_W-1:0] DEPTH_PTR = PTR_W'(BUFFER_DEPTH);

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT   = 3'd0,
    ACT_DELETE   = 3'd1,
    ACT_FORWARD  = 3'd2,
    ACT_BACKWARD = 3'd3,
    ACT_TO_START = 3'd4,
    ACT_TO_END   = 3'd5,
    ACT_READ     = 3'd6
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NO_EFFECT = 2'd2
  } status_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [PTR_W-1:0]  cursor;
    logic [CHAR_W-1:0] chr;
  } cell_ctl_t;

endpackage

FILE: hdl/ctbe_cell.sv
// ----------------------------------------------------------------------------
// ctbe_cell: one character cell of the buffer row
// Holds one byte; on insert it takes its left neighbor or the new byte, on
// delete its right neighbor. Drives its byte onto the read bus when selected.
// ----------------------------------------------------------------------------
module ctbe_cell
  import ctbe_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  cell_ctl_t         ctl,
  input  logic [CHAR_W-1:0] left_in,
  input  logic [CHAR_W-1:0] right_in,
  input  logic [RIDX_W-1:0] read_index,
  output logic [CHAR_W-1:0] value,
  output logic [CHAR_W-1:0] read_out
);

  logic [PTR_W-1:0] pos;
  logic             at_cursor;
  logic             past_cursor;

  assign pos         = PTR_W'(idx);
  assign at_cursor   = (pos == ctl.cursor);
  assign past_cursor = (pos > ctl.cursor);

  // Shift with the tail of the text
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (at_cursor) begin
        value <= ctl.chr;
      end else if (past_cursor) begin
        value <= left_in;
      end
    end else if (ctl.del && (at_cursor || past_cursor)) begin
      value <= right_in;
    end
  end

  // Gate the byte onto the OR read bus
  assign read_out = (PTR_W'(read_index) == pos) ? value : '0;

endmodule

FILE: hdl/ctbe_ctrl.sv
// ----------------------------------------------------------------------------
// ctbe_ctrl: command decode with cursor and length registers
// Works out the next cursor and length, the status, and the shift command
// that goes to the cell row.
// ----------------------------------------------------------------------------
module ctbe_ctrl
  import ctbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  action_t           action,
  input  logic [CHAR_W-1:0] char_in,
  input  logic [RIDX_W-1:0] read_index,
  output cell_ctl_t         cell_ctl,
  output logic [PTR_W-1:0]  cursor_next,
  output logic [PTR_W-1:0]  length_next,
  output status_t           status,
  output logic              read_ok,
  output logic [PTR_W-1:0]  cursor_reg,
  output logic [PTR_W-1:0]  length_reg
);

  logic do_ins;
  logic do_del;

  // Decode the command
  always_comb begin
    cursor_next = cursor_reg;
    length_next = length_reg;
    status      = ST_DONE;
    read_ok     = 1'b0;
    do_ins      = 1'b0;
    do_del      = 1'b0;
    case (action)
      ACT_INSERT: begin
        if (length_reg == DEPTH_PTR) begin
          status = ST_FULL;
        end else begin
          do_ins      = 1'b1;
          cursor_next = cursor_reg + PTR_W'(1);
          length_next = length_reg + PTR_W'(1);
        end
      end
      ACT_DELETE: begin
        if (cursor_reg < length_reg) begin
          do_del      = 1'b1;
          length_next = length_reg - PTR_W'(1);
        end else begin
          status = ST_NO_EFFECT;
        end
      end
      ACT_FORWARD: begin
        if (cursor_reg < length_reg) begin
          cursor_next = cursor_reg + PTR_W'(1);
        end else begin
          status = ST_NO_EFFECT;
        end
      end
      ACT_BACKWARD: begin
        if (cursor_reg != '0) begin
          cursor_next = cursor_reg - PTR_W'(1);
        end else begin
          status = ST_NO_EFFECT;
        end
      end
      ACT_TO_START: cursor_next = '0;
      ACT_TO_END:   cursor_next = length_reg;
      ACT_READ: begin
        if (PTR_W'(read_index) < length_reg) begin
          read_ok = 1'b1;
        end else begin
          status = ST_NO_EFFECT;
        end
      end
      default: status = ST_NO_EFFECT;
    endcase
  end

  // Shift command for the row, only on an accepted transaction
  assign cell_ctl.ins    = accept && do_ins;
  assign cell_ctl.del    = accept && do_del;
  assign cell_ctl.cursor = cursor_reg;
  assign cell_ctl.chr    = char_in;

  // Advance cursor and length
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_reg <= '0;
      length_reg <= '0;
    end else if (accept) begin
      cursor_reg <= cursor_next;
      length_reg <= length_next;
    end
  end

endmodule

FILE: hdl/cursor_text_buffer_editor.sv
// ----------------------------------------------------------------------------
// cursor_text_buffer_editor: fixed-depth text buffer with an edit cursor
//
//   channel | dir | handshake          | contents
//   s_*     | in  | s_tvalid/s_tready  | tuser: action; tdata: char_in, read_index
//   m_*     | out | m_tvalid/m_tready  | tdata: cursor_pos, text_length,
//           |     |                    |        char_out, status
//
// One command per cycle; a row of BUFFER_DEPTH byte cells shifts the whole
// tail at the edge that accepts the command, and the result is loaded into
// the output register at that same edge and offered from the next cycle.
// Reset clears cursor, length and the output valid; cell contents are not
// cleared, and a cell is only read below the length, so after it was written.
// A stalled result holds the output register; a new command is taken in the
// same cycle the waiting result is taken.
// ----------------------------------------------------------------------------
module cursor_text_buffer_editor
  import ctbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] char_in, [13:8] read_index, [15:14] zero
  input  logic [2:0]  s_tuser,   // [2:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [6:0] cursor_pos, [13:7] text_length,
                                 // [21:14] char_out, [23:22] status
);

  logic              accept;
  action_t           action;
  logic [CHAR_W-1:0] char_in;
  logic [RIDX_W-1:0] read_index;
  cell_ctl_t         cell_ctl;
  logic [PTR_W-1:0]  cursor_next;
  logic [PTR_W-1:0]  length_next;
  status_t           status;
  logic              read_ok;
  logic [PTR_W-1:0]  cursor_reg;
  logic [PTR_W-1:0]  length_reg;

  logic [CHAR_W-1:0] cell_val  [BUFFER_DEPTH];
  logic [CHAR_W-1:0] cell_rd   [BUFFER_DEPTH];
  logic [CHAR_W-1:0] read_byte;

  logic [PTR_W-1:0]  cursor_pos;
  logic [PTR_W-1:0]  text_length;
  logic [CHAR_W-1:0] char_out;
  status_t           status_q;

  // Unpack the input transaction
  assign action     = action_t'(s_tuser);
  assign char_in    = s_tdata[7:0];
  assign read_index = s_tdata[13:8];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  ctbe_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .action      (action),
    .char_in     (char_in),
    .read_index  (read_index),
    .cell_ctl    (cell_ctl),
    .cursor_next (cursor_next),
    .length_next (length_next),
    .status      (status),
    .read_ok     (read_ok),
    .cursor_reg  (cursor_reg),
    .length_reg  (length_reg)
  );

  // Row of character cells
  for (genvar k = 0; k < BUFFER_DEPTH; k++) begin : g_cell
    logic [CHAR_W-1:0] left_in;
    logic [CHAR_W-1:0] right_in;

    if (k == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_inner_l
      assign left_in = cell_val[k-1];
    end
    if (k == BUFFER_DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_inner_r
      assign right_in = cell_val[k+1];
    end

    ctbe_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(k)),
      .ctl        (cell_ctl),
      .left_in    (left_in),
      .right_in   (right_in),
      .read_index (read_index),
      .value      (cell_val[k]),
      .read_out   (cell_rd[k])
    );
  end

  // Merge the read bus
  always_comb begin
    read_byte = '0;
    for (int i = 0; i < BUFFER_DEPTH; i++) begin
      read_byte = read_byte | cell_rd[i];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cursor_pos  <= cursor_next;
      text_length <= length_next;
      char_out    <= read_ok ? read_byte : '0;
      status_q    <= status;
    end
  end

  assign m_tdata = {status_q, char_out, text_length, cursor_pos};

  // Checks
  a_cursor_in_text: assert property (@(posedge clk) disable iff (rst)
    cursor_reg <= length_reg)
    else $error("cursor beyond text length");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    length_reg <= DEPTH_PTR)
    else $error("text length beyond buffer depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_INSERT && length_reg != DEPTH_PTR)
      |=> (length_reg == $past(length_reg) + PTR_W'(1)))
    else $error("accepted insert did not grow the text");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status_q == ST_FULL) |-> (text_length == DEPTH_PTR))
    else $error("full status with room left");

  a_char_only_on_read: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && char_out != '0) |-> (status_q == ST_DONE))
    else $error("character reported without a successful read");

endmodule
